// File: rtl/core/glc_pkg.sv
// shared types and constants for the glyph descriptor lru cache
`default_nettype none

package glc_pkg;

  // operation codes
  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_INSERT = 1'b1;

  // number of valid font size classes
  localparam int SIZE_KINDS = 4;

  // starting value of the least-stamp search, one above any stamp
  localparam logic [16:0] STAMP_CEIL = 17'h10000;

  // widths of stored fields
  localparam int METRICS_W = 44;
  localparam int STAMP_W   = 16;

  // request item
  typedef struct packed {
    logic              func;
    logic [1:0]        font_size;
    logic [15:0]       char_code;
    logic [1:0]        pixel_depth_code;
    logic [2:0]        flag_bits;
    logic [6:0]        advance;
    logic [7:0]        glyph_width;
    logic [7:0]        glyph_height;
    logic signed [7:0] x_offset;
    logic signed [7:0] y_offset;
    logic [31:0]       data_addr;
  } in_item_t;

  // result item
  typedef struct packed {
    logic              found;
    logic [1:0]        hit_depth_code;
    logic [2:0]        hit_flags;
    logic [6:0]        hit_advance;
    logic [7:0]        hit_width;
    logic [7:0]        hit_height;
    logic signed [7:0] hit_x_offset;
    logic signed [7:0] hit_y_offset;
    logic [31:0]       hit_addr;
  } out_item_t;

  // one stored entry: key and descriptor
  typedef struct packed {
    logic [1:0]           size_tag;
    logic [15:0]          code;
    logic [METRICS_W-1:0] metrics;
    logic [31:0]          address;
  } entry_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// File: rtl/core/glc_if.sv
// valid/ready channel interfaces for request and result items
`default_nettype none

interface glc_in_if;
  logic             valid;
  logic             ready;
  glc_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface glc_out_if;
  logic              valid;
  logic              ready;
  glc_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/glyph_info_lru_cache_top.sv
// glyph descriptor lru cache: one entry scanned per cycle under a small sequencer
// flow: a lookup hit or an insert goes from the scan through the write step to the result,
//   a miss goes from the scan straight to the result, an out-of-range size class skips the scan
// throughput: one item at a time, next accept in the cycle after the result loads; set by the scan
// reset: valid and stamp-live bits clear on reset, so the store reads as all zero
//   with no clearing pass; the stamp counter returns to zero
`default_nettype none

module glyph_info_lru_cache_top #(
  parameter int ENTRIES = 16
) (
  input  wire logic  clk,
  input  wire logic  rst,
  glc_in_if.sink     req,
  glc_out_if.source  rsp
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int EW = $bits(glc_pkg::entry_t);

  // registers
  glc_pkg::state_t    state, state_next;
  glc_pkg::in_item_t  item;
  glc_pkg::out_item_t res;
  glc_pkg::out_item_t rsp_data;
  logic               rsp_valid;
  logic [CW-1:0]      rd_cnt;
  logic               cmp_valid;
  logic [IW-1:0]      cmp_idx;
  logic [IW-1:0]      target;
  logic [16:0]        least;
  logic [15:0]        stamp_counter;
  logic [ENTRIES-1:0] valid;
  logic [ENTRIES-1:0] live;

  // ram ports
  logic                 key_we;
  glc_pkg::entry_t      key_wdata;
  logic [EW-1:0]        key_rdata;
  logic                 stamp_we;
  logic [15:0]          stamp_wdata;
  logic [15:0]          stamp_rdata;
  logic                 issue;

  // compare stage signals
  glc_pkg::entry_t      cur_key;
  logic [15:0]          cur_stamp;
  logic                 is_last;
  logic                 is_insert;
  logic                 size_ok;
  logic                 key_match;
  logic                 free_hit;
  logic                 stamp_less;
  logic                 accept;
  logic                 load_out;
  logic [15:0]          stamp_inc;
  logic                 wrap;
  logic [15:0]          new_stamp;
  glc_pkg::entry_t      new_entry;

  glc_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (target),
    .wdata (key_wdata),
    .re    (issue),
    .raddr (rd_cnt[IW-1:0]),
    .rdata (key_rdata)
  );

  glc_ram #(.WIDTH(glc_pkg::STAMP_W), .DEPTH(ENTRIES)) u_stamp_ram (
    .clk   (clk),
    .we    (stamp_we),
    .waddr (target),
    .wdata (stamp_wdata),
    .re    (issue),
    .raddr (rd_cnt[IW-1:0]),
    .rdata (stamp_rdata)
  );

  // handshake
  assign req.ready = (state == glc_pkg::S_IDLE);
  assign accept    = req.valid && req.ready;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;
  assign load_out  = (state == glc_pkg::S_DONE) && (!rsp_valid || rsp.ready);

  // compare stage: entries never written read as zero
  assign cur_key    = valid[cmp_idx] ? glc_pkg::entry_t'(key_rdata) : '0;
  assign cur_stamp  = live[cmp_idx] ? stamp_rdata : '0;
  assign is_last    = (cmp_idx == IW'(ENTRIES - 1));
  assign is_insert  = (item.func == glc_pkg::FUNC_INSERT);
  assign size_ok    = (32'(req.data.font_size) < glc_pkg::SIZE_KINDS);
  assign key_match  = (cur_key.size_tag == item.font_size) && (cur_key.code == item.char_code);
  assign free_hit   = (cur_key.code == 16'd0) || (cur_stamp == 16'd0);
  assign stamp_less = ({1'b0, cur_stamp} < least);
  assign issue      = (state == glc_pkg::S_SCAN) && (rd_cnt < CW'(ENTRIES));

  // fresh stamp, with wrap back to one
  assign stamp_inc = stamp_counter + 16'd1;
  assign wrap      = (stamp_inc == 16'd0);
  assign new_stamp = wrap ? 16'd1 : stamp_inc;

  // descriptor to store on insert
  always_comb begin
    new_entry.size_tag = item.font_size;
    new_entry.code     = item.char_code;
    new_entry.metrics  = {item.y_offset, item.x_offset, item.glyph_height, item.glyph_width,
                          item.advance, item.flag_bits, item.pixel_depth_code};
    new_entry.address  = item.data_addr;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      glc_pkg::S_IDLE: begin
        if (accept) begin
          state_next = size_ok ? glc_pkg::S_SCAN : glc_pkg::S_DONE;
        end
      end
      glc_pkg::S_SCAN: begin
        if (cmp_valid) begin
          if (is_insert) begin
            if (free_hit || is_last) begin
              state_next = glc_pkg::S_WRITE;
            end
          end else if (key_match) begin
            state_next = glc_pkg::S_WRITE;
          end else if (is_last) begin
            state_next = glc_pkg::S_DONE;
          end
        end
      end
      glc_pkg::S_WRITE: state_next = glc_pkg::S_DONE;
      glc_pkg::S_DONE: begin
        if (load_out) begin
          state_next = glc_pkg::S_IDLE;
        end
      end
      default: state_next = glc_pkg::S_IDLE;
    endcase
  end

  // ram write controls
  always_comb begin
    stamp_we    = 1'b0;
    key_we      = 1'b0;
    stamp_wdata = new_stamp;
    key_wdata   = new_entry;
    case (state)
      glc_pkg::S_WRITE: begin
        stamp_we = 1'b1;
        key_we   = is_insert;
      end
      default: begin
        stamp_we = 1'b0;
        key_we   = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= glc_pkg::S_IDLE;
      rsp_valid     <= 1'b0;
      cmp_valid     <= 1'b0;
      rd_cnt        <= '0;
      stamp_counter <= '0;
      valid         <= '0;
      live          <= '0;
    end else begin
      state     <= state_next;
      cmp_valid <= issue;
      if (accept) begin
        rd_cnt <= '0;
      end else if (issue) begin
        rd_cnt <= rd_cnt + CW'(1);
      end
      if (load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      // stamp update, clearing every stamp on wrap
      if (state == glc_pkg::S_WRITE) begin
        stamp_counter <= new_stamp;
        live <= (wrap ? {ENTRIES{1'b0}} : live) | (ENTRIES'(1) << target);
        if (is_insert) begin
          valid[target] <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (issue) begin
      cmp_idx <= rd_cnt[IW-1:0];
    end
    if (accept) begin
      item   <= req.data;
      res    <= '0;
      target <= '0;
      least  <= glc_pkg::STAMP_CEIL;
    end else if (state == glc_pkg::S_SCAN && cmp_valid) begin
      if (is_insert) begin
        if (free_hit) begin
          target <= cmp_idx;
        end else if (stamp_less) begin
          target <= cmp_idx;
          least  <= {1'b0, cur_stamp};
        end
      end else if (key_match) begin
        target             <= cmp_idx;
        res.found          <= 1'b1;
        res.hit_depth_code <= cur_key.metrics[1:0];
        res.hit_flags      <= cur_key.metrics[4:2];
        res.hit_advance    <= cur_key.metrics[11:5];
        res.hit_width      <= cur_key.metrics[19:12];
        res.hit_height     <= cur_key.metrics[27:20];
        res.hit_x_offset   <= $signed(cur_key.metrics[35:28]);
        res.hit_y_offset   <= $signed(cur_key.metrics[43:36]);
        res.hit_addr       <= cur_key.address;
      end
    end
    if (load_out) begin
      rsp_data <= res;
    end
  end

  // the stamp counter never holds zero once a stamp has been handed out
  a_stamp_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == glc_pkg::S_WRITE |=> stamp_counter != 16'd0)
    else $error("stamp counter zero after stamp update");

  // the written entry always carries a live stamp afterward
  a_target_live: assert property (@(posedge clk) disable iff (rst)
    state == glc_pkg::S_WRITE |=> live[target])
    else $error("written entry has no live stamp");

  // a result without a hit has zero address, width, height and advance
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_data.found |-> rsp_data.hit_addr == 32'd0 &&
      rsp_data.hit_width == 8'd0 && rsp_data.hit_height == 8'd0 &&
      rsp_data.hit_advance == 7'd0)
    else $error("miss result carries nonzero descriptor");

  // an insert never reports a hit
  a_insert_no_found: assert property (@(posedge clk) disable iff (rst)
    state == glc_pkg::S_DONE && is_insert |-> !res.found)
    else $error("insert produced a hit result");

  // a lookup only reaches the write step through a match
  a_lookup_write: assert property (@(posedge clk) disable iff (rst)
    state == glc_pkg::S_WRITE && !is_insert |-> res.found)
    else $error("lookup stamp update without a hit");

endmodule

`default_nettype wire

// File: rtl/core/glc_ram.sv
// generic single write port ram with registered read
`default_nettype none

module glc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output      logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: tb/glc_lru_watch.sv
// watches the request and result channels, models the lru cache and compares each result
`default_nettype none

module glc_lru_watch #(
  parameter int ENTRIES = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  glc_in_if    req,
  glc_out_if   rsp,
  output int   mismatch_count,
  output int   outstanding,
  output int   lookup_total,
  output int   hit_total,
  output int   insert_total,
  output int   evict_total,
  output int   wrap_total
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_CAP = 50;

  // modeled store: key, stamp and descriptor per entry
  logic [1:0]         tag_mem   [ENTRIES];
  logic [15:0]        code_mem  [ENTRIES];
  logic [15:0]        stamp_mem [ENTRIES];
  glc_pkg::out_item_t desc_mem  [ENTRIES];
  logic [15:0]        stamp_ctr;

  // results still owed by the block, oldest first
  glc_pkg::out_item_t expected_rsp [$];
  int                 rsp_index;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("ERROR: %s", msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                                rsp_index, name, got, want));
  endtask

  // pre-incremented stamp; a wrap to zero clears every stamp and restarts at one
  function automatic logic [15:0] fresh_stamp();
    stamp_ctr = stamp_ctr + 16'd1;
    if (stamp_ctr == 16'd0) begin
      for (int i = 0; i < ENTRIES; i++)
        stamp_mem[i] = 16'd0;
      stamp_ctr = 16'd1;
      wrap_total++;
    end
    return stamp_ctr;
  endfunction

  // apply one request to the modeled store and work out its result
  task automatic cache_access(input glc_pkg::in_item_t it, output glc_pkg::out_item_t res);
    bit          hit;
    bit          free;
    int          victim;
    logic [16:0] least;
    res = '0;
    if (int'(it.font_size) >= glc_pkg::SIZE_KINDS)
      return;
    if (it.func == glc_pkg::FUNC_LOOKUP) begin
      // first matching entry wins, empty entries included
      lookup_total++;
      hit = 1'b0;
      for (int i = 0; i < ENTRIES && !hit; i++) begin
        if (tag_mem[i] == it.font_size && code_mem[i] == it.char_code) begin
          hit = 1'b1;
          stamp_mem[i] = fresh_stamp();
          res = desc_mem[i];
          res.found = 1'b1;
        end
      end
      if (hit)
        hit_total++;
    end else begin
      // victim: first free slot, else first slot with the oldest stamp
      insert_total++;
      free = 1'b0;
      victim = 0;
      least = glc_pkg::STAMP_CEIL;
      for (int i = 0; i < ENTRIES && !free; i++) begin
        if (code_mem[i] == 16'd0 || stamp_mem[i] == 16'd0) begin
          free = 1'b1;
          victim = i;
        end else if (least > {1'b0, stamp_mem[i]}) begin
          least = {1'b0, stamp_mem[i]};
          victim = i;
        end
      end
      if (!free)
        evict_total++;
      stamp_mem[victim] = fresh_stamp();
      tag_mem[victim] = it.font_size;
      code_mem[victim] = it.char_code;
      desc_mem[victim] = '{found: 1'b0,
                           hit_depth_code: it.pixel_depth_code,
                           hit_flags: it.flag_bits,
                           hit_advance: it.advance,
                           hit_width: it.glyph_width,
                           hit_height: it.glyph_height,
                           hit_x_offset: it.x_offset,
                           hit_y_offset: it.y_offset,
                           hit_addr: it.data_addr};
    end
  endtask

  // sample both channels at each edge
  always @(posedge clk) begin : watch
    glc_pkg::out_item_t want;
    glc_pkg::out_item_t got;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        tag_mem[i] = '0;
        code_mem[i] = '0;
        stamp_mem[i] = '0;
        desc_mem[i] = '0;
      end
      stamp_ctr = '0;
      expected_rsp.delete();
      outstanding <= 0;
    end else begin
      if (req.valid === 1'b1 && req.ready === 1'b1) begin
        cache_access(req.data, want);
        expected_rsp.push_back(want);
      end
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
        got = rsp.data;
        if (expected_rsp.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", rsp_index));
        end else begin
          want = expected_rsp.pop_front();
          check_field("found", {31'b0, got.found}, {31'b0, want.found});
          check_field("hit_depth_code", {30'b0, got.hit_depth_code},
                      {30'b0, want.hit_depth_code});
          check_field("hit_flags", {29'b0, got.hit_flags}, {29'b0, want.hit_flags});
          check_field("hit_advance", {25'b0, got.hit_advance}, {25'b0, want.hit_advance});
          check_field("hit_width", {24'b0, got.hit_width}, {24'b0, want.hit_width});
          check_field("hit_height", {24'b0, got.hit_height}, {24'b0, want.hit_height});
          check_field("hit_x_offset", {24'b0, got.hit_x_offset},
                      {24'b0, want.hit_x_offset});
          check_field("hit_y_offset", {24'b0, got.hit_y_offset},
                      {24'b0, want.hit_y_offset});
          check_field("hit_addr", got.hit_addr, want.hit_addr);
        end
        rsp_index++;
      end
      outstanding <= expected_rsp.size();
    end
  end

endmodule

`default_nettype wire

// File: tb/tb.sv
// top of the lru cache testbench: clock, reset, request stimulus, result idling, verdict
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES        = 16;
  localparam int REPEAT_LOOKUPS = 40;
  localparam int RANDOM_ITEMS   = 640;
  localparam int HOLD_CYCLES    = 300;
  localparam int POOL_KEYS      = 24;

  logic clk;
  logic rst;

  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  bit hold_go;

  int mismatch_count;
  int outstanding;
  int lookup_total;
  int hit_total;
  int insert_total;
  int evict_total;
  int wrap_total;

  // small key space so that lookups hit and inserts evict
  logic [1:0]  pool_size [POOL_KEYS];
  logic [15:0] pool_code [POOL_KEYS];

  glc_in_if  req_ch ();
  glc_out_if rsp_ch ();

  glyph_info_lru_cache_top #(
    .ENTRIES(ENTRIES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  glc_lru_watch #(
    .ENTRIES(ENTRIES)
  ) lru_watch (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .mismatch_count(mismatch_count),
    .outstanding(outstanding),
    .lookup_total(lookup_total),
    .hit_total(hit_total),
    .insert_total(insert_total),
    .evict_total(evict_total),
    .wrap_total(wrap_total)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // overall time limit
  initial begin
    #1_000_000;
    $display("glyph_info_lru_cache_top verification failed");
    $finish;
  end

  // result side: one long hold-off once asked for, else random idling
  always @(posedge clk) begin
    if (hold_go && hold_left < HOLD_CYCLES) begin
      hold_left = hold_left + 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic glc_pkg::in_item_t make_item(input logic func, input logic [1:0] size,
                                         input logic [15:0] code, input logic [1:0] depth,
                                         input logic [2:0] flags, input logic [6:0] adv,
                                         input logic [7:0] w, input logic [7:0] h,
                                         input logic [7:0] xo, input logic [7:0] yo,
                                         input logic [31:0] addr);
    glc_pkg::in_item_t it;
    it.func = func;
    it.font_size = size;
    it.char_code = code;
    it.pixel_depth_code = depth;
    it.flag_bits = flags;
    it.advance = adv;
    it.glyph_width = w;
    it.glyph_height = h;
    it.x_offset = xo;
    it.y_offset = yo;
    it.data_addr = addr;
    return it;
  endfunction

  // mostly pooled keys, some fully random; payload always random
  function automatic glc_pkg::in_item_t random_item();
    logic [95:0]       raw;
    glc_pkg::in_item_t it;
    int                slot;
    raw = {$urandom, $urandom, $urandom};
    it = raw[94:0];
    it.func = ($urandom_range(99) < 40) ? glc_pkg::FUNC_INSERT : glc_pkg::FUNC_LOOKUP;
    if ($urandom_range(99) < 85) begin
      slot = $urandom_range(POOL_KEYS - 1);
      it.font_size = pool_size[slot];
      it.char_code = pool_code[slot];
    end
    return it;
  endfunction

  // offer one item, optionally after idle cycles, and hold it until taken
  task automatic send_item(input glc_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= it;
    @(posedge clk);
    while (req_ch.ready !== 1'b1)
      @(posedge clk);
  endtask

  // stimulus
  initial begin
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.data <= '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_go = 1'b0;
    pool_size[0] = 2'd0;
    pool_code[0] = 16'h0000;
    pool_size[1] = 2'd3;
    pool_code[1] = 16'hFFFF;
    for (int i = 2; i < POOL_KEYS; i++) begin
      pool_size[i] = 2'($urandom_range(3));
      pool_code[i] = 16'($urandom);
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty store: size 0 code 0 hits entry zero, other keys miss
    send_item(make_item(glc_pkg::FUNC_LOOKUP, 2'd0, 16'h0000, 2'd3, 3'd7, 7'h7F, 8'hFF, 8'hFF,
                        8'h7F, 8'h80, 32'hFFFF_FFFF));
    send_item(make_item(glc_pkg::FUNC_LOOKUP, 2'd3, 16'hFFFF, 2'd0, 3'd0, 7'h00, 8'h00, 8'h00,
                        8'h00, 8'h00, 32'h0));
    // first insert lands in entry zero, max payload
    send_item(make_item(glc_pkg::FUNC_INSERT, 2'd1, 16'h1234, 2'd3, 3'd7, 7'h7F, 8'hFF, 8'hFF,
                        8'h7F, 8'h80, 32'hFFFF_FFFF));
    send_item(make_item(glc_pkg::FUNC_LOOKUP, 2'd1, 16'h1234, 2'd0, 3'd0, 7'h00, 8'h00, 8'h00,
                        8'h00, 8'h00, 32'h0));
    // top key, min payload with opposite offset extremes
    send_item(make_item(glc_pkg::FUNC_INSERT, 2'd3, 16'hFFFF, 2'd0, 3'd0, 7'h00, 8'h00, 8'h00,
                        8'h80, 8'h7F, 32'h0));
    send_item(make_item(glc_pkg::FUNC_LOOKUP, 2'd3, 16'hFFFF, 2'd1, 3'd2, 7'h15, 8'h5A, 8'hA5,
                        8'h01, 8'hFF, 32'h8000_0001));
    // code 0 key stays a free slot, so the next insert overwrites it
    send_item(make_item(glc_pkg::FUNC_INSERT, 2'd2, 16'h0000, 2'd2, 3'd5, 7'h2A, 8'h33, 8'hCC,
                        8'hF0, 8'h0F, 32'hDEAD_BEEF));
    send_item(make_item(glc_pkg::FUNC_LOOKUP, 2'd2, 16'h0000, 2'd0, 3'd0, 7'h00, 8'h00, 8'h00,
                        8'h00, 8'h00, 32'h0));
    // duplicate key: lookup keeps taking the lower entry
    send_item(make_item(glc_pkg::FUNC_INSERT, 2'd1, 16'h1234, 2'd1, 3'd1, 7'h01, 8'h01, 8'h02,
                        8'hFE, 8'h02, 32'h0000_1000));
    send_item(make_item(glc_pkg::FUNC_LOOKUP, 2'd1, 16'h1234, 2'd0, 3'd0, 7'h00, 8'h00, 8'h00,
                        8'h00, 8'h00, 32'h0));
    send_item(make_item(glc_pkg::FUNC_LOOKUP, 2'd2, 16'h0000, 2'd0, 3'd0, 7'h00, 8'h00, 8'h00,
                        8'h00, 8'h00, 32'h0));
    send_item(make_item(glc_pkg::FUNC_LOOKUP, 2'd0, 16'h0000, 2'd0, 3'd0, 7'h00, 8'h00, 8'h00,
                        8'h00, 8'h00, 32'h0));
    send_item(make_item(glc_pkg::FUNC_LOOKUP, 2'd1, 16'h1235, 2'd0, 3'd0, 7'h00, 8'h00, 8'h00,
                        8'h00, 8'h00, 32'h0));

    // repeated hits on one entry, with lookup payload that must be ignored
    for (int n = 0; n < REPEAT_LOOKUPS; n++)
      send_item(make_item(glc_pkg::FUNC_LOOKUP, 2'd1, 16'h1234, 2'(n), 3'(n), 7'(n), 8'(n),
                          8'(n >> 8), 8'(n), 8'(n >> 4), 32'(n)));

    // random traffic under three idling mixes, long result hold-off in the last
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 0) begin
        send_idle_pct = 15;
        recv_idle_pct = 76;
      end else if (n == RANDOM_ITEMS / 3) begin
        send_idle_pct = 76;
        recv_idle_pct = 15;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_go = 1'b1;
      end
      send_item(random_item());
    end
    req_ch.valid <= 1'b0;

    // drain, then allow for a stray late result
    @(posedge clk);
    while (outstanding != 0)
      @(posedge clk);
    repeat (ENTRIES + 8) @(posedge clk);

    $display("run covered %0d lookups with %0d hits, %0d inserts, %0d evictions, %0d wraps",
             lookup_total, hit_total, insert_total, evict_total, wrap_total);
    $display("directed corners, %0d repeat hits, %0d random items, %0d-cycle result hold-off",
             REPEAT_LOOKUPS, RANDOM_ITEMS, HOLD_CYCLES);
    if (mismatch_count == 0 && outstanding == 0)
      $display("glyph_info_lru_cache_top verification clean");
    else
      $display("glyph_info_lru_cache_top verification failed");
    $finish;
  end

endmodule

`default_nettype wire
